// ===== rtl/chst_pkg.sv =====
package chst_pkg;

  // Default number of samples held in the table.
  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int SMP_W  = 32;  // sample and position width
  localparam int IDX_W  = 10;  // sample index and segment count width
  localparam int TAN_W  = 35;  // twice the tangent times h
  localparam int COEF_W = 38;  // Hermite coefficients A2 and B2
  localparam int ACC_W  = 44;  // Horner accumulators
  localparam int T_W    = 17;  // offset within the segment, unsigned Q1.16
  localparam int RES_W  = 48;  // result width
  localparam int MUL_W  = 64;  // output of the reciprocal scaling units

  localparam logic [63:0] OUT_LIM  = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] WIDE_LIM = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_VALUE  = 2'd1,
    REQ_DERIV1 = 2'd2,
    REQ_DERIV2 = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_NEG = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_SEG_CNT = 2'd0,
    CFG_SEG_W   = 2'd1,
    CFG_INV_W   = 2'd2
  } cfg_idx_t;

  // Operating mode of one reciprocal scaling unit.
  typedef struct packed {
    logic byp;   // pass the operand through untouched
    logic s17;   // shift by 17 rather than 16
    logic wide;  // clamp to the wide intermediate range
  } mulsh_mode_t;

endpackage

// ===== rtl/chst_bank_mem.sv =====
module chst_bank_mem #(
  parameter int ROW_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ROW_W-1:0]  wr_row,
  input  logic [31:0]       wr_data,
  input  logic              rd_en,
  input  logic [ROW_W-1:0]  rd_row,
  output logic [31:0]       rd_data
);

  logic [31:0] mem_r [2**ROW_W];
  logic [31:0] rd_data_r;

  // A read in the same cycle as a write to the same row returns the old word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/chst_horner.sv =====
module chst_horner
  import chst_pkg::*;
(
  input  logic                     clk,
  input  logic [3:0]               en_i,
  input  req_t                     req_i,
  input  logic [T_W-1:0]           t_i,
  input  logic signed [COEF_W-1:0] a2_i,
  input  logic signed [COEF_W-1:0] b2_i,
  input  logic signed [SMP_W-1:0]  y0_i,
  input  logic signed [TAN_W-1:0]  e0_i,
  output logic signed [ACC_W-1:0]  v1_o,
  output logic signed [ACC_W-1:0]  v2_o,
  output logic signed [ACC_W-1:0]  val_o
);

  localparam int KA_W = COEF_W + 2;
  localparam int P1_W = KA_W + T_W + 1;
  localparam int P2_W = ACC_W + T_W + 1;

  // Stage 1: leading coefficient times t.
  logic signed [P1_W-1:0]  prod1_r;
  logic signed [COEF_W:0]  c1_r;
  logic [T_W-1:0]          t1_r;
  logic signed [SMP_W-1:0] y0_1_r;
  logic signed [TAN_W-1:0] e0_1_r;

  // Stage 2 and 3: Horner steps.
  logic signed [P2_W-1:0]  prod2_r, prod3_r;
  logic signed [ACC_W-1:0] v1_2_r, v1_3_r, v2_3_r;
  logic [T_W-1:0]          t2_r;
  logic signed [SMP_W-1:0] y0_2_r, y0_3_r;
  logic signed [TAN_W-1:0] e0_2_r;

  // Stage 4: results.
  logic signed [ACC_W-1:0] v1_4_r, v2_4_r, val4_r;

  logic signed [KA_W-1:0]  ka2_nxt;
  logic signed [COEF_W:0]  c1_nxt;
  logic signed [ACC_W-1:0] v1_nxt, v2_nxt, v3_nxt;

  always_comb begin
    if (req_i == REQ_VALUE) begin
      ka2_nxt = KA_W'(a2_i);
      c1_nxt  = (COEF_W+1)'(b2_i);
    end else begin
      ka2_nxt = (KA_W'(a2_i) <<< 1) + KA_W'(a2_i);
      c1_nxt  = (req_i == REQ_DERIV1) ? ((COEF_W+1)'(b2_i) <<< 1) : (COEF_W+1)'(b2_i);
    end
    v1_nxt = ACC_W'(c1_r) + ACC_W'(prod1_r >>> 16);
    v2_nxt = ACC_W'(e0_2_r) + ACC_W'(prod2_r >>> 16);
    v3_nxt = (ACC_W'(y0_3_r) <<< 1) + ACC_W'(prod3_r >>> 16);
  end

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      prod1_r <= P1_W'(ka2_nxt) * P1_W'($signed({1'b0, t_i}));
      c1_r    <= c1_nxt;
      t1_r    <= t_i;
      y0_1_r  <= y0_i;
      e0_1_r  <= e0_i;
    end
    if (en_i[1]) begin
      v1_2_r  <= v1_nxt;
      prod2_r <= P2_W'(v1_nxt) * P2_W'($signed({1'b0, t1_r}));
      t2_r    <= t1_r;
      y0_2_r  <= y0_1_r;
      e0_2_r  <= e0_1_r;
    end
    if (en_i[2]) begin
      v1_3_r  <= v1_2_r;
      v2_3_r  <= v2_nxt;
      prod3_r <= P2_W'(v2_nxt) * P2_W'($signed({1'b0, t2_r}));
      y0_3_r  <= y0_2_r;
    end
    if (en_i[3]) begin
      v1_4_r <= v1_3_r;
      v2_4_r <= v2_3_r;
      val4_r <= v3_nxt >>> 1;
    end
  end

  assign v1_o  = v1_4_r;
  assign v2_o  = v2_4_r;
  assign val_o = val4_r;

endmodule

// ===== rtl/chst_mulsh.sv =====
module chst_mulsh
  import chst_pkg::*;
#(
  parameter int IW = 44,
  parameter int OW = 64
) (
  input  logic                 clk,
  input  logic [3:0]           en_i,
  input  mulsh_mode_t          mode_i,
  input  logic signed [IW-1:0] a_i,
  input  logic [31:0]          b_i,
  input  logic                 sat_i,
  output logic signed [OW-1:0] y_o,
  output logic                 sat_o
);

  localparam int HB = (IW + 1) / 2;
  localparam int LW = HB + 32;
  localparam int UW = IW - HB + 32;
  localparam int FW = IW + 32;
  localparam int CW = (FW > 64) ? FW : 64;

  mulsh_mode_t          mode1_r, mode2_r, mode3_r;
  logic                 neg1_r, neg2_r, neg3_r;
  logic                 sat1_r, sat2_r, sat3_r, sat4_r;
  logic signed [IW-1:0] raw1_r, raw2_r, raw3_r;
  logic [IW-1:0]        mag1_r;
  logic [LW-1:0]        lo2_r;
  logic [UW-1:0]        hi2_r;
  logic [63:0]          r3_r;
  logic signed [OW-1:0] y4_r;

  logic [IW-1:0] mag_nxt;
  logic [FW-1:0] full_nxt, shr_nxt;
  logic [63:0]   cap_nxt, r_nxt;
  logic          ovf_nxt;

  always_comb begin
    mag_nxt  = a_i[IW-1] ? IW'(-a_i) : IW'(a_i);
    full_nxt = (FW'(hi2_r) << HB) + FW'(lo2_r);
    shr_nxt  = mode2_r.s17 ? (full_nxt >> 17) : (full_nxt >> 16);
    cap_nxt  = (mode2_r.wide ? WIDE_LIM : OUT_LIM) + 64'(neg2_r);
    ovf_nxt  = CW'(shr_nxt) > CW'(cap_nxt);
    r_nxt    = ovf_nxt ? cap_nxt : 64'(shr_nxt);
  end

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      mode1_r <= mode_i;
      neg1_r  <= a_i[IW-1];
      mag1_r  <= mag_nxt;
      raw1_r  <= a_i;
      sat1_r  <= sat_i;
    end
    if (en_i[1]) begin
      mode2_r <= mode1_r;
      neg2_r  <= neg1_r;
      lo2_r   <= LW'(mag1_r[HB-1:0]) * LW'(b_i);
      hi2_r   <= UW'(mag1_r[IW-1:HB]) * UW'(b_i);
      raw2_r  <= raw1_r;
      sat2_r  <= sat1_r;
    end
    if (en_i[2]) begin
      mode3_r <= mode2_r;
      neg3_r  <= neg2_r;
      r3_r    <= r_nxt;
      raw3_r  <= raw2_r;
      sat3_r  <= sat2_r | (ovf_nxt & ~mode2_r.byp);
    end
    if (en_i[3]) begin
      if (mode3_r.byp) begin
        y4_r <= OW'(raw3_r);
      end else if (neg3_r) begin
        y4_r <= -$signed(OW'(r3_r));
      end else begin
        y4_r <= $signed(OW'(r3_r));
      end
      sat4_r <= sat3_r;
    end
  end

  assign y_o   = y4_r;
  assign sat_o = sat4_r;

endmodule

// ===== rtl/cubic_hermite_spline_table_core.sv =====
// Channel   Ports                                   Direction
// -------   -------------------------------------   ---------
// in        in_valid/in_stall, request fields       in
// out       out_valid/out_stall, result, status     out
// cfg       cfg_wr_en, cfg_index, cfg_wdata          in
//
// One beat is accepted per clock unless in_stall is high; each beat gives one result beat.
// The pipeline depth is set by the four-bank sample memory and the chain
// of multipliers: segment index, offset, Horner steps and two reciprocal scalings.
// Reset clears the valid bits and presets the config registers; the sample table is not
// cleared, so no clearing pass is needed and beats are accepted straight away.
// A stall on the output holds only full stages; empty stages still fill.
module cubic_hermite_spline_table_core
  import chst_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_req_type,
  input  logic [IDX_W-1:0]        in_sample_index,
  input  logic signed [SMP_W-1:0] in_sample_value,
  input  logic signed [SMP_W-1:0] in_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RES_W-1:0] out_result_value,
  output logic [1:0]              out_status,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_wdata
);

  // The samples are spread over four banks by the two low index bits, so the
  // four neighbours of a segment always fall in different banks.
  localparam int BANK_RW = ($clog2((TABLE_DEPTH + 3) / 4) > 0) ?
                           $clog2((TABLE_DEPTH + 3) / 4) : 1;
  localparam logic [31:0] TD_W = 32'(TABLE_DEPTH);
  localparam int NS = 19;
  localparam int KW = IDX_W + 1;

  typedef struct packed {
    req_t req;
    logic neg;
  } side_t;

  // Configuration registers.
  logic [IDX_W-1:0] seg_cnt_r;
  logic [31:0]      seg_w_r, inv_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r <= IDX_W'(1023);
      seg_w_r   <= 32'd65536;
      inv_w_r   <= 32'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SEG_CNT: seg_cnt_r <= cfg_wdata[IDX_W-1:0];
        CFG_SEG_W:   seg_w_r   <= cfg_wdata;
        CFG_INV_W:   inv_w_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or when the stage after
  // it loads, so bubbles close up while the output is stalled.
  logic [NS:1] stg_vld_r;
  logic [NS:1] stg_en;

  for (genvar g = 1; g <= NS; g++) begin : g_en
    assign stg_en[g] = !out_stall || !(&stg_vld_r[NS:g]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
    end else begin
      if (stg_en[1]) begin
        stg_vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (stg_en[k]) begin
          stg_vld_r[k] <= stg_vld_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !stg_en[1];
  assign out_valid = stg_vld_r[NS];

  // Stage 1: input registers.
  req_t                    req1_r, req2_r, req3_r, req4_r, req5_r, req6_r;
  logic [IDX_W-1:0]        idx1_r, idx2_r, idx3_r;
  logic signed [SMP_W-1:0] val1_r, val2_r, val3_r;
  logic signed [SMP_W-1:0] x1_r, x2_r, x3_r, x4_r;

  // Stage 2: raw segment index.
  logic [31:0] q2_r;
  logic [63:0] q_prod_nxt;

  // Stage 3: clamped segment index.
  logic [IDX_W-1:0] i3_r, n_eff_nxt, nm1_nxt, i_nxt;
  logic             first3_r, last3_r;

  // Stage 4: memory data and i*h.
  logic [41:0] ih4_r;
  logic [1:0]  rot4_r;
  logic [3:0]  zf4_r;
  logic        first4_r, last4_r;

  // Stage 5: offset, samples and tangents.
  logic [31:0]             dx5_r;
  logic signed [SMP_W-1:0] y0_5_r, y1_5_r;
  logic signed [TAN_W-1:0] e0_5_r, e1_5_r;
  logic                    neg5_r;

  // Stage 6: t and Hermite coefficients.
  logic [T_W-1:0]           t6_r;
  logic signed [COEF_W-1:0] a2_6_r, b2_6_r;
  logic signed [SMP_W-1:0]  y0_6_r;
  logic signed [TAN_W-1:0]  e0_6_r;
  logic                     neg6_r;

  always_comb begin
    q_prod_nxt = {32'd0, x1_r} * {32'd0, inv_w_r};
    n_eff_nxt  = (seg_cnt_r == '0) ? IDX_W'(1) : seg_cnt_r;
    nm1_nxt    = n_eff_nxt - IDX_W'(1);
    i_nxt      = (q2_r > 32'(nm1_nxt)) ? nm1_nxt : q2_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      req1_r <= req_t'(in_req_type);
      idx1_r <= in_sample_index;
      val1_r <= in_sample_value;
      x1_r   <= in_position;
    end
    if (stg_en[2]) begin
      q2_r   <= q_prod_nxt[63:32];
      req2_r <= req1_r;
      idx2_r <= idx1_r;
      val2_r <= val1_r;
      x2_r   <= x1_r;
    end
    if (stg_en[3]) begin
      i3_r     <= i_nxt;
      first3_r <= (i_nxt == '0);
      last3_r  <= (i_nxt == nm1_nxt);
      req3_r   <= req2_r;
      idx3_r   <= idx2_r;
      val3_r   <= val2_r;
      x3_r     <= x2_r;
    end
  end

  // Sample memory. The window starts one sample before the segment; a write
  // is applied in the same stage as the reads, so beats see writes in order.
  logic [KW-1:0]      k0;
  logic [KW-1:0]      kj [4];
  logic [3:0]         zf_nxt;
  logic [BANK_RW-1:0] rd_row [4];
  logic [31:0]        rdata [4];
  logic               wr_go;

  always_comb begin
    k0 = {1'b0, i3_r} - KW'(1);
    for (int j = 0; j < 4; j++) begin
      kj[j]     = k0 + KW'(j);
      zf_nxt[j] = 32'(kj[j]) >= TD_W;
    end
    wr_go = stg_vld_r[3] && stg_en[4] && (req3_r == REQ_WRITE) && (32'(idx3_r) < TD_W);
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0]    sel;
    logic [KW-1:0] krow;

    assign sel        = 2'(b) - k0[1:0];
    assign krow       = k0 + KW'(sel);
    assign rd_row[b]  = BANK_RW'(krow >> 2);

    chst_bank_mem #(
      .ROW_W (BANK_RW)
    ) u_bank (
      .clk     (clk),
      .wr_en   (wr_go && (idx3_r[1:0] == 2'(b))),
      .wr_row  (BANK_RW'(idx3_r >> 2)),
      .wr_data (val3_r),
      .rd_en   (stg_en[4]),
      .rd_row  (rd_row[b]),
      .rd_data (rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      ih4_r    <= 42'(i3_r) * 42'(seg_w_r);
      rot4_r   <= k0[1:0];
      zf4_r    <= zf_nxt;
      first4_r <= first3_r;
      last4_r  <= last3_r;
      req4_r   <= req3_r;
      x4_r     <= x3_r;
    end
  end

  // Stage 5 logic: rotate the bank outputs back into window order.
  logic signed [SMP_W-1:0] yw [4];
  logic signed [TAN_W-1:0] ym1_x, y0_x, y1_x, y2_x;
  logic signed [43:0]      dx_full;
  logic [31:0]             dx_nxt;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      yw[j] = zf4_r[j] ? '0 : $signed(rdata[rot4_r + 2'(j)]);
    end
    ym1_x = TAN_W'(yw[0]);
    y0_x  = TAN_W'(yw[1]);
    y1_x  = TAN_W'(yw[2]);
    y2_x  = TAN_W'(yw[3]);
    dx_full = $signed({13'd0, x4_r[30:0]}) - $signed({2'd0, ih4_r});
    if (dx_full[43]) begin
      dx_nxt = '0;
    end else if (dx_full > $signed({12'd0, seg_w_r})) begin
      dx_nxt = seg_w_r;
    end else begin
      dx_nxt = dx_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[5]) begin
      dx5_r  <= dx_nxt;
      y0_5_r <= yw[1];
      y1_5_r <= yw[2];
      // One-sided differences at the first and last samples.
      e0_5_r <= first4_r ? ((y1_x - y0_x) <<< 1) : (y1_x - ym1_x);
      e1_5_r <= last4_r ? ((y1_x - y0_x) <<< 1) : (y2_x - y0_x);
      req5_r <= req4_r;
      neg5_r <= x4_r[31];
    end
  end

  // Stage 6 logic: t = dx/h, capped at one, and the cubic coefficients.
  logic [63:0]              t_prod;
  logic [47:0]              t_full;
  logic signed [COEF_W-1:0] y0_w, y1_w, e0_w, e1_w, dy_w;

  always_comb begin
    t_prod = {32'd0, dx5_r} * {32'd0, inv_w_r};
    t_full = t_prod[63:16];
    y0_w   = COEF_W'(y0_5_r);
    y1_w   = COEF_W'(y1_5_r);
    e0_w   = COEF_W'(e0_5_r);
    e1_w   = COEF_W'(e1_5_r);
    dy_w   = y1_w - y0_w;
  end

  always_ff @(posedge clk) begin
    if (stg_en[6]) begin
      t6_r   <= (t_full > 48'd65536) ? T_W'(65536) : t_full[T_W-1:0];
      a2_6_r <= (y0_w <<< 2) + e0_w - (y1_w <<< 2) + e1_w;
      b2_6_r <= (dy_w <<< 2) + (dy_w <<< 1) - (e0_w <<< 1) - e1_w;
      y0_6_r <= y0_5_r;
      e0_6_r <= e0_5_r;
      req6_r <= req5_r;
      neg6_r <= neg5_r;
    end
  end

  // Stages 7 to 10: Horner evaluation.
  logic signed [ACC_W-1:0] v1, v2, valres;

  chst_horner u_horner (
    .clk   (clk),
    .en_i  (stg_en[10:7]),
    .req_i (req6_r),
    .t_i   (t6_r),
    .a2_i  (a2_6_r),
    .b2_i  (b2_6_r),
    .y0_i  (y0_6_r),
    .e0_i  (e0_6_r),
    .v1_o  (v1),
    .v2_o  (v2),
    .val_o (valres)
  );

  // Request kind and sign flag travel alongside the arithmetic.
  side_t                   side_r [7:NS-1];
  logic signed [ACC_W-1:0] val_r  [11:NS-1];

  always_ff @(posedge clk) begin
    if (stg_en[7]) begin
      side_r[7] <= '{req: req6_r, neg: neg6_r};
    end
    for (int k = 8; k <= NS - 1; k++) begin
      if (stg_en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
    if (stg_en[11]) begin
      val_r[11] <= valres;
    end
    for (int k = 12; k <= NS - 1; k++) begin
      if (stg_en[k]) begin
        val_r[k] <= val_r[k-1];
      end
    end
  end

  // Stages 11 to 18: scaling by 1/h. The first derivative takes one scaling
  // with a shift of 17; the second derivative takes two with a shift of 16.
  mulsh_mode_t             mode_a, mode_b;
  logic signed [ACC_W-1:0] a_in;
  logic signed [MUL_W-1:0] mid, fin;
  logic                    sat_a, sat_b;

  always_comb begin
    mode_a.byp  = (side_r[10].req == REQ_WRITE) || (side_r[10].req == REQ_VALUE);
    mode_a.s17  = (side_r[10].req == REQ_DERIV1);
    mode_a.wide = (side_r[10].req == REQ_DERIV2);
    a_in        = (side_r[10].req == REQ_DERIV1) ? v2 : v1;
    mode_b.byp  = (side_r[14].req != REQ_DERIV2);
    mode_b.s17  = 1'b0;
    mode_b.wide = 1'b0;
  end

  chst_mulsh #(
    .IW (ACC_W),
    .OW (MUL_W)
  ) u_mulsh_a (
    .clk    (clk),
    .en_i   (stg_en[14:11]),
    .mode_i (mode_a),
    .a_i    (a_in),
    .b_i    (inv_w_r),
    .sat_i  (1'b0),
    .y_o    (mid),
    .sat_o  (sat_a)
  );

  chst_mulsh #(
    .IW (MUL_W),
    .OW (MUL_W)
  ) u_mulsh_b (
    .clk    (clk),
    .en_i   (stg_en[18:15]),
    .mode_i (mode_b),
    .a_i    (mid),
    .b_i    (inv_w_r),
    .sat_i  (sat_a),
    .y_o    (fin),
    .sat_o  (sat_b)
  );

  // Stage 19: output register.
  logic signed [RES_W-1:0] res_r, res_nxt;
  status_t                 status_r, status_nxt;

  always_comb begin
    res_nxt    = '0;
    status_nxt = ST_OK;
    case (side_r[NS-1].req)
      REQ_WRITE: begin
        res_nxt    = '0;
        status_nxt = ST_OK;
      end
      REQ_VALUE: begin
        res_nxt    = RES_W'(val_r[NS-1]);
        status_nxt = ST_OK;
      end
      default: begin
        res_nxt    = fin[RES_W-1:0];
        status_nxt = sat_b ? ST_SAT : ST_OK;
      end
    endcase
    // A negative position overrides any evaluation.
    if (side_r[NS-1].req != REQ_WRITE && side_r[NS-1].neg) begin
      res_nxt    = '0;
      status_nxt = ST_NEG;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[NS]) begin
      res_r    <= res_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_result_value = res_r;
  assign out_status       = status_r;

endmodule
